>>> sv/assert_macros.svh
// assertion macros shared by the allocation map modules
// depends on nothing; taken in by `include where assertions are written
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked outside reset
`define ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/amc_pkg.sv
// types and constants for the allocation map mark/clear unit
// used by amc_ctrl, amc_datapath and the top level; depends on nothing
package amc_pkg;

   // default map size and fixed field widths
   localparam int unsigned MapEntriesDefault = 4096;
   localparam int unsigned IdxW = 12;
   localparam int unsigned LenW = 13;
   localparam int unsigned CntW = 13;

   // map entry codes
   typedef enum logic [1:0] {
      MARK_FREE  = 2'd0,
      MARK_START = 2'd1,
      MARK_CONT  = 2'd2
   } mark_type;

   // request kinds
   typedef enum logic {
      KIND_MARK  = 1'b0,
      KIND_CLEAR = 1'b1
   } kind_type;

   // response status codes
   localparam logic STATUS_OK  = 1'b0;
   localparam logic STATUS_ERR = 1'b1;

   // request and response words
   typedef struct packed {
      kind_type         kind;
      logic [IdxW-1:0]  start_index;
      logic [LenW-1:0]  length;
   } req_type;

   typedef struct packed {
      logic             status;
      logic [CntW-1:0]  entries_changed;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CHECK,
      ST_SCAN,
      ST_DRAIN,
      ST_FILL,
      ST_CLR_RD,
      ST_CLR_HEAD,
      ST_CLR_WALK
   } state_type;

   // pointer and counter operations
   typedef enum logic [1:0] {
      PTR_HOLD,
      PTR_START,
      PTR_NEXT
   } ptr_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD,
      CNT_ONE,
      CNT_NEXT
   } cnt_op_type;

   // controller to datapath commands
   typedef struct packed {
      logic        req_load;
      ptr_op_type  ptr_op;
      logic        rd_en;
      logic        rd_next;
      logic        wr_en;
      mark_type    wr_mark;
      cnt_op_type  cnt_op;
      logic        bad_clr;
      logic        rsp_load;
      logic        rsp_err;
      logic        rsp_use_len;
   } cmd_type;

   // datapath to controller status
   typedef struct packed {
      kind_type  kind;
      logic      pre_err;
      logic      ptr_at_start;
      logic      ptr_last_run;
      logic      ptr_at_last;
      logic      ptr_in_map;
      logic      next_in_map;
      logic      scan_bad;
      logic      rd_is_start;
      logic      rd_is_cont;
   } stat_type;

endpackage

>>> sv/amc_ctrl.sv
// controller state machine for the allocation map mark/clear unit
// depends on amc_pkg and assert_macros.svh; drives amc_datapath by command word
`include "assert_macros.svh"

module amc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  amc_pkg::stat_type  stat,
   output amc_pkg::cmd_type   cmd
);

   amc_pkg::state_type state_ff;
   amc_pkg::state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= amc_pkg::ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         amc_pkg::ST_INIT: begin
            if (stat.ptr_at_last) state_in = amc_pkg::ST_IDLE;
         end
         amc_pkg::ST_IDLE: begin
            if (start) state_in = amc_pkg::ST_CHECK;
         end
         amc_pkg::ST_CHECK: begin
            if (stat.pre_err) begin
               state_in = amc_pkg::ST_IDLE;
            end else if (stat.kind == amc_pkg::KIND_MARK) begin
               state_in = amc_pkg::ST_SCAN;
            end else begin
               state_in = amc_pkg::ST_CLR_RD;
            end
         end
         amc_pkg::ST_SCAN: begin
            if (stat.ptr_last_run) state_in = amc_pkg::ST_DRAIN;
         end
         amc_pkg::ST_DRAIN: begin
            state_in = stat.scan_bad ? amc_pkg::ST_IDLE : amc_pkg::ST_FILL;
         end
         amc_pkg::ST_FILL: begin
            if (stat.ptr_last_run) state_in = amc_pkg::ST_IDLE;
         end
         amc_pkg::ST_CLR_RD: begin
            state_in = amc_pkg::ST_CLR_HEAD;
         end
         amc_pkg::ST_CLR_HEAD: begin
            state_in = stat.rd_is_start ? amc_pkg::ST_CLR_WALK : amc_pkg::ST_IDLE;
         end
         amc_pkg::ST_CLR_WALK: begin
            if (!(stat.ptr_in_map && stat.rd_is_cont)) state_in = amc_pkg::ST_IDLE;
         end
         default: begin
            state_in = amc_pkg::ST_IDLE;
         end
      endcase
   end

   // command outputs
   always_comb begin
      cmd             = '0;
      cmd.ptr_op      = amc_pkg::PTR_HOLD;
      cmd.cnt_op      = amc_pkg::CNT_HOLD;
      cmd.wr_mark     = amc_pkg::MARK_FREE;
      busy            = 1'b1;
      unique case (state_ff)
         amc_pkg::ST_INIT: begin
            // clearing pass, one entry per cycle
            cmd.wr_en  = 1'b1;
            cmd.ptr_op = amc_pkg::PTR_NEXT;
         end
         amc_pkg::ST_IDLE: begin
            busy         = 1'b0;
            cmd.req_load = start;
         end
         amc_pkg::ST_CHECK: begin
            cmd.ptr_op  = amc_pkg::PTR_START;
            cmd.bad_clr = 1'b1;
            if (stat.pre_err) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = 1'b1;
            end
         end
         amc_pkg::ST_SCAN: begin
            // read one entry per cycle, checked in the cycle after the read
            cmd.rd_en  = 1'b1;
            cmd.ptr_op = amc_pkg::PTR_NEXT;
         end
         amc_pkg::ST_DRAIN: begin
            cmd.ptr_op = amc_pkg::PTR_START;
            if (stat.scan_bad) begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = 1'b1;
            end
         end
         amc_pkg::ST_FILL: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_mark = stat.ptr_at_start ? amc_pkg::MARK_START : amc_pkg::MARK_CONT;
            cmd.ptr_op  = amc_pkg::PTR_NEXT;
            if (stat.ptr_last_run) begin
               cmd.rsp_load    = 1'b1;
               cmd.rsp_use_len = 1'b1;
            end
         end
         amc_pkg::ST_CLR_RD: begin
            cmd.rd_en = 1'b1;
         end
         amc_pkg::ST_CLR_HEAD: begin
            if (stat.rd_is_start) begin
               cmd.wr_en   = 1'b1;
               cmd.rd_en   = stat.next_in_map;
               cmd.rd_next = 1'b1;
               cmd.ptr_op  = amc_pkg::PTR_NEXT;
               cmd.cnt_op  = amc_pkg::CNT_ONE;
            end else begin
               cmd.rsp_load = 1'b1;
               cmd.rsp_err  = 1'b1;
            end
         end
         amc_pkg::ST_CLR_WALK: begin
            // free continuation entries while reading the one after
            if (stat.ptr_in_map && stat.rd_is_cont) begin
               cmd.wr_en   = 1'b1;
               cmd.rd_en   = stat.next_in_map;
               cmd.rd_next = 1'b1;
               cmd.ptr_op  = amc_pkg::PTR_NEXT;
               cmd.cnt_op  = amc_pkg::CNT_NEXT;
            end else begin
               cmd.rsp_load = 1'b1;
            end
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // assertions
   `ASSERT_NEXT(a_rsp_then_idle, clock, reset, cmd.rsp_load, state_ff == amc_pkg::ST_IDLE,
      "response issued without return to idle")
   `ASSERT_IMPLIES(a_no_write_on_entry, clock, reset,
      state_ff == amc_pkg::ST_IDLE || state_ff == amc_pkg::ST_CHECK, !cmd.wr_en,
      "map written before a request was checked")

endmodule

>>> sv/amc_datapath.sv
// datapath for the allocation map mark/clear unit: map memory, pointer, counter
// depends on amc_pkg and assert_macros.svh; driven by amc_ctrl commands
`include "assert_macros.svh"

module amc_datapath #(
   parameter int unsigned MAP_ENTRIES = amc_pkg::MapEntriesDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  amc_pkg::req_type   req_data,
   input  amc_pkg::cmd_type   cmd,
   output amc_pkg::stat_type  stat,
   output logic               rsp_strobe,
   output amc_pkg::rsp_type   rsp_data
);

   localparam int unsigned AW    = $clog2(MAP_ENTRIES);
   // one bit over the widest operand so start + length never wraps
   localparam int unsigned PTR_W = ((AW + 1 > amc_pkg::LenW) ? AW + 1 : amc_pkg::LenW) + 1;
   localparam logic [PTR_W-1:0] MapLimit = PTR_W'(MAP_ENTRIES);
   localparam logic [PTR_W-1:0] MapLast  = PTR_W'(MAP_ENTRIES - 1);

   amc_pkg::req_type            req_ff;
   logic [PTR_W-1:0]            ptr_ff;
   logic [PTR_W-1:0]            ptr_in;
   logic [amc_pkg::CntW-1:0]    cnt_ff;
   logic [amc_pkg::CntW-1:0]    cnt_in;
   logic                        bad_ff;
   logic                        bad_now;
   logic                        rd_vld_ff;
   amc_pkg::mark_type           rd_data_ff;
   amc_pkg::mark_type           map_ff [MAP_ENTRIES];
   logic [AW-1:0]               rd_addr;
   logic [PTR_W-1:0]            next_ptr;
   logic [PTR_W-1:0]            start_ext;
   logic [PTR_W-1:0]            len_ext;
   logic [PTR_W-1:0]            end_ptr;
   logic                        rsp_valid_ff;
   amc_pkg::rsp_type            rsp_ff;
   amc_pkg::rsp_type            rsp_in;

   // request word latch
   always_ff @(posedge clock) begin
      if (cmd.req_load) req_ff <= req_data;
   end

   // segment bounds
   assign start_ext = {{(PTR_W - amc_pkg::IdxW){1'b0}}, req_ff.start_index};
   assign len_ext   = {{(PTR_W - amc_pkg::LenW){1'b0}}, req_ff.length};
   assign end_ptr   = start_ext + len_ext;
   assign next_ptr  = ptr_ff + PTR_W'(1);

   // walking pointer
   always_comb begin
      case (cmd.ptr_op)
         amc_pkg::PTR_START: ptr_in = start_ext;
         amc_pkg::PTR_NEXT:  ptr_in = next_ptr;
         default:            ptr_in = ptr_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff <= '0;
      end else begin
         ptr_ff <= ptr_in;
      end
   end

   // entries freed counter, wraps at the field width
   always_comb begin
      case (cmd.cnt_op)
         amc_pkg::CNT_ONE:  cnt_in = amc_pkg::CntW'(1);
         amc_pkg::CNT_NEXT: cnt_in = cnt_ff + amc_pkg::CntW'(1);
         default:           cnt_in = cnt_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
   end

   // map memory, one write and one read port, registered read
   assign rd_addr = cmd.rd_next ? next_ptr[AW-1:0] : ptr_ff[AW-1:0];

   always_ff @(posedge clock) begin
      if (cmd.wr_en) map_ff[ptr_ff[AW-1:0]] <= cmd.wr_mark;
      if (cmd.rd_en) rd_data_ff <= map_ff[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff <= 1'b0;
      end else begin
         rd_vld_ff <= cmd.rd_en;
      end
   end

   // sticky flag for a used entry seen during the free scan
   assign bad_now = bad_ff | (rd_vld_ff & (rd_data_ff != amc_pkg::MARK_FREE));

   always_ff @(posedge clock) begin
      if (reset || cmd.bad_clr) begin
         bad_ff <= 1'b0;
      end else begin
         bad_ff <= bad_now;
      end
   end

   // status back to the controller
   always_comb begin
      stat.kind         = req_ff.kind;
      if (req_ff.kind == amc_pkg::KIND_MARK) begin
         stat.pre_err = (req_ff.length == '0) || (start_ext >= MapLimit) ||
                        (end_ptr > MapLimit);
      end else begin
         stat.pre_err = (start_ext >= MapLimit);
      end
      stat.ptr_at_start = (ptr_ff == start_ext);
      stat.ptr_last_run = (next_ptr == end_ptr);
      stat.ptr_at_last  = (ptr_ff == MapLast);
      stat.ptr_in_map   = (ptr_ff < MapLimit);
      stat.next_in_map  = (next_ptr < MapLimit);
      stat.scan_bad     = bad_now;
      stat.rd_is_start  = (rd_data_ff == amc_pkg::MARK_START);
      stat.rd_is_cont   = (rd_data_ff == amc_pkg::MARK_CONT);
   end

   // response word register
   always_comb begin
      if (cmd.rsp_err) begin
         rsp_in.status          = amc_pkg::STATUS_ERR;
         rsp_in.entries_changed = '0;
      end else begin
         rsp_in.status          = amc_pkg::STATUS_OK;
         rsp_in.entries_changed = cmd.rsp_use_len ? req_ff.length : cnt_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) rsp_ff <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.rsp_load;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // assertions
   `ASSERT_IMPLIES(a_write_in_map, clock, reset, cmd.wr_en, ptr_ff < MapLimit,
      "map write beyond last entry")
   `ASSERT_IMPLIES(a_cont_in_segment, clock, reset,
      cmd.wr_en && cmd.wr_mark == amc_pkg::MARK_CONT,
      ptr_ff < end_ptr && ptr_ff > start_ext, "continuation written outside segment")
   `ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff,
      "response strobe held for more than one cycle")

endmodule

>>> sv/allocation_map_mark_clear_unit.sv
// top level of the allocation map mark/clear unit
// depends on amc_pkg, amc_ctrl and amc_datapath
//
//   channel   ports                          handshake
//   request   start, busy, req_data          taken when start && !busy
//   response  rsp_strobe, rsp_data           one cycle, no back pressure
//
// after reset the map is swept to free, with busy high until the sweep ends
// mark: accept, check, scan, drain, fill, then the strobe (scan then fill, one entry a cycle)
// clear: accept, check, read the head entry, free it, then free each continuation entry
// rejected: at the check for a bad request, after scan and drain for a used entry, at the head for a non-start clear
// busy drops with the strobe; the receiver takes every word on its strobe, no stall
module allocation_map_mark_clear_unit #(
   parameter int unsigned MAP_ENTRIES = amc_pkg::MapEntriesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  amc_pkg::req_type  req_data,
   output logic              rsp_strobe,
   output amc_pkg::rsp_type  rsp_data
);

   amc_pkg::cmd_type  cmd;
   amc_pkg::stat_type stat;

   // sequencer
   amc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   // map storage and walk logic
   amc_datapath #(
      .MAP_ENTRIES (MAP_ENTRIES)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .stat       (stat),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
